>>> rtl/core/wto_pkg.sv
// shared types and constants of the wavetable oscillator
package wto_pkg;

  localparam int unsigned TableSize     = 2048;
  localparam int unsigned TableAw       = 11;
  localparam int unsigned LenBits       = 12;
  localparam int unsigned PhaseBits     = 32;
  localparam int unsigned PhaseFracBits = 21;
  localparam int unsigned SampleBits    = 16;
  localparam int unsigned AmpBits       = 16;
  localparam int unsigned CalcBits      = 24;
  localparam int unsigned CfgIdxBits    = 2;
  localparam int unsigned CfgDataBits   = 32;

  // operation codes
  localparam logic OpTick  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // register indexes
  localparam logic [CfgIdxBits-1:0] CfgTableLength = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgPhaseStep   = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgAmplitude   = 2'd2;

  localparam logic [LenBits-1:0]   TableLengthReset = 12'd2048;
  localparam logic [PhaseBits-1:0] PhaseStepReset   = 32'd0;
  localparam logic [AmpBits-1:0]   AmplitudeReset   = 16'd32768;

  typedef struct packed {
    logic                         operation;
    logic [TableAw-1:0]           entry_index;
    logic signed [SampleBits-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         clipped;
    logic                         step_clamped;
  } out_item_t;

endpackage

>>> rtl/core/wto_if.sv
// valid/ready channels for input and result items
interface wto_in_if;
  logic              valid;
  logic              ready;
  wto_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wto_out_if;
  logic               valid;
  logic               ready;
  wto_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/wto_ram.sv
// generic single write port, single read port ram with registered read
module wto_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/wavetable_oscillator_cubic.sv
// wavetable oscillator with catmull-rom cubic interpolation
//
//   channel | dir | handshake    | payload
//   in_i    | in  | valid/ready  | operation, entry_index, entry_value
//   out_o   | out | valid/ready  | sample, clipped, step_clamped
//   cfg     | in  | cfg_we_i     | cfg_index_i, cfg_data_i (write only)
//
// a write item leaves the input ready, and the next item can follow at once.
// a tick item holds the input until its result enters the output register: the four table
// reads go one after another through the single read port of the table ram,
// then three horner steps share one multiplier and the gain uses another.
// when a lowered table length leaves the phase far out of range, the phase
// wrap first runs a restoring reduction.
// reset clears the phase and returns the registers to their reset values; the table is not cleared.
// a result waits in the output register while the next item is accepted.
module wavetable_oscillator_cubic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wto_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [wto_pkg::CfgDataBits-1:0]     cfg_data_i,
  wto_in_if.sink                              in_i,
  wto_out_if.source                           out_o
);

  localparam int unsigned LB  = wto_pkg::LenBits;
  localparam int unsigned PB  = wto_pkg::PhaseBits;
  localparam int unsigned FB  = wto_pkg::PhaseFracBits;
  localparam int unsigned AW  = wto_pkg::TableAw;
  localparam int unsigned SB  = wto_pkg::SampleBits;
  localparam int unsigned CB  = wto_pkg::CalcBits;
  localparam int unsigned UB  = 16;
  localparam int unsigned KB  = 4;
  localparam int unsigned HPB = CB + UB + 1;
  localparam int unsigned GPB = SB + wto_pkg::AmpBits + 1;
  localparam int unsigned GB  = GPB - 15;

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StAdv    = 10'b0000000010,
    StWrap   = 10'b0000000100,
    StMod    = 10'b0000001000,
    StRead   = 10'b0000010000,
    StCoef   = 10'b0000100000,
    StHorner = 10'b0001000000,
    StSat    = 10'b0010000000,
    StGain   = 10'b0100000000,
    StFin    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [LB-1:0]                   table_length_q;
  logic [PB-1:0]                   phase_step_q;
  logic [wto_pkg::AmpBits-1:0]     amplitude_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= wto_pkg::TableLengthReset;
      phase_step_q   <= wto_pkg::PhaseStepReset;
      amplitude_q    <= wto_pkg::AmplitudeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wto_pkg::CfgTableLength: table_length_q <= cfg_data_i[LB-1:0];
        wto_pkg::CfgPhaseStep:   phase_step_q   <= cfg_data_i[PB-1:0];
        wto_pkg::CfgAmplitude:   amplitude_q    <= cfg_data_i[wto_pkg::AmpBits-1:0];
        default: ;
      endcase
    end
  end

  // effective length 1..TableSize
  logic [LB-1:0] len;
  always_comb begin
    if (table_length_q == '0) begin
      len = LB'(1);
    end else if (table_length_q > LB'(wto_pkg::TableSize)) begin
      len = LB'(wto_pkg::TableSize);
    end else begin
      len = table_length_q;
    end
  end

  logic [PB:0] limit;
  logic [PB-1:0] step_cl;
  logic          step_big;
  assign limit    = {len, {FB{1'b0}}} ;
  assign step_big = {1'b0, phase_step_q} >= limit;
  assign step_cl  = step_big ? PB'(limit - (PB+1)'(1)) : phase_step_q;

  // datapath registers
  logic [PB-1:0]             phase_q, phase_d;
  logic [PB:0]               sum_q, sum_d;
  logic                      clamped_q, clamped_d;
  logic [LB-1:0]             rem_q, rem_d;
  logic [KB-1:0]             k_q, k_d;
  logic [2:0]                rd_cnt_q, rd_cnt_d;
  logic [1:0]                h_cnt_q, h_cnt_d;
  logic signed [SB-1:0]      y_q [4];
  logic signed [CB-1:0]      t_q, t_d, b_q, b_d, c_q, c_d, e_q, e_d;
  logic signed [SB-1:0]      v_q, v_d;
  logic                      clip_q, clip_d;
  logic signed [GB-1:0]      g_q, g_d;
  logic                      out_valid_q, out_valid_d;
  wto_pkg::out_item_t        out_data_q, out_data_d;

  logic in_fire;
  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;

  // neighbor indices around the integer phase
  logic [AW-1:0] idx, i0, i2, i3;
  logic [LB-1:0] i2_w, i3_w;
  assign idx  = phase_q[PB-1:FB];
  assign i0   = (idx == '0) ? AW'(len - LB'(1)) : AW'(idx - AW'(1));
  assign i2_w = ({1'b0, idx} + LB'(1) >= len) ? {1'b0, idx} + LB'(1) - len
                                               : {1'b0, idx} + LB'(1);
  assign i2   = i2_w[AW-1:0];
  assign i3_w = ({1'b0, i2} + LB'(1) >= len) ? {1'b0, i2} + LB'(1) - len
                                              : {1'b0, i2} + LB'(1);
  assign i3   = i3_w[AW-1:0];

  logic signed [UB:0] u_s;
  assign u_s = $signed({1'b0, phase_q[FB-1:FB-UB]});

  // table memory
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [SB-1:0] rd_data;

  always_comb begin
    case (rd_cnt_q[1:0])
      2'd0:    rd_addr = i0;
      2'd1:    rd_addr = idx;
      2'd2:    rd_addr = i2;
      default: rd_addr = i3;
    endcase
  end
  assign rd_en = (state_q == StRead) && (rd_cnt_q != 3'd4);

  wto_ram #(
    .WIDTH (SB),
    .DEPTH (wto_pkg::TableSize)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_i.data.operation == wto_pkg::OpWrite)),
    .waddr_i (in_i.data.entry_index),
    .wdata_i (in_i.data.entry_value),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // main sequencer
  always_comb begin
    logic [LB-1:0]        sum_int;
    logic [LB+AW-1:0]     div;
    logic [LB-1:0]        rem_n;
    logic signed [CB-1:0] ye [4];
    logic signed [HPB-1:0] hp;
    logic signed [CB-1:0] addend;
    logic signed [CB-1:0] half;
    logic signed [GPB-1:0] gp;

    state_d     = state_q;
    phase_d     = phase_q;
    sum_d       = sum_q;
    clamped_d   = clamped_q;
    rem_d       = rem_q;
    k_d         = k_q;
    rd_cnt_d    = rd_cnt_q;
    h_cnt_d     = h_cnt_q;
    t_d         = t_q;
    b_d         = b_q;
    c_d         = c_q;
    e_d         = e_q;
    v_d         = v_q;
    clip_d      = clip_q;
    g_d         = g_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;

    sum_int = sum_q[PB:FB];
    div     = {{AW{1'b0}}, len} << k_q;
    rem_n   = ({{AW{1'b0}}, rem_q} >= div) ? rem_q - div[LB-1:0] : rem_q;
    for (int i = 0; i < 4; i++) begin
      ye[i] = CB'(y_q[i]);
    end
    hp = t_q * u_s + HPB'(32768);
    case (h_cnt_q)
      2'd0:    addend = b_q;
      2'd1:    addend = c_q;
      default: addend = e_q;
    endcase
    half = (t_q + CB'(1)) >>> 1;
    gp   = v_q * $signed({1'b0, amplitude_q}) + GPB'(16384);

    unique case (state_q)
      StIdle: begin
        if (in_fire && (in_i.data.operation == wto_pkg::OpTick)) begin
          state_d = StAdv;
        end
      end
      StAdv: begin
        sum_d     = {1'b0, phase_q} + {1'b0, step_cl};
        clamped_d = step_big;
        state_d   = StWrap;
      end
      StWrap: begin
        if ({1'b0, sum_int} < {len, 1'b0}) begin
          rem_n    = (sum_int >= len) ? sum_int - len : sum_int;
          phase_d  = {rem_n[AW-1:0], sum_q[FB-1:0]};
          rd_cnt_d = '0;
          state_d  = StRead;
        end else begin
          rem_d   = sum_int;
          k_d     = KB'(LB - 1);
          state_d = StMod;
        end
      end
      StMod: begin
        rem_d = rem_n;
        k_d   = k_q - KB'(1);
        if (k_q == '0) begin
          phase_d  = {rem_n[AW-1:0], sum_q[FB-1:0]};
          rd_cnt_d = '0;
          state_d  = StRead;
        end
      end
      StRead: begin
        rd_cnt_d = rd_cnt_q + 3'd1;
        if (rd_cnt_q == 3'd4) begin
          state_d = StCoef;
        end
      end
      StCoef: begin
        // coefficients kept doubled
        t_d     = (ye[3] - ye[0]) + CB'(3) * (ye[1] - ye[2]);
        b_d     = CB'(2) * ye[0] - CB'(5) * ye[1] + CB'(4) * ye[2] - ye[3];
        c_d     = ye[2] - ye[0];
        e_d     = CB'(2) * ye[1];
        h_cnt_d = '0;
        state_d = StHorner;
      end
      StHorner: begin
        t_d     = hp[CB+15:16] + addend;
        h_cnt_d = h_cnt_q + 2'd1;
        if (h_cnt_q == 2'd2) begin
          state_d = StSat;
        end
      end
      StSat: begin
        clip_d = 1'b0;
        if (half > CB'(32767)) begin
          v_d    = SB'(32767);
          clip_d = 1'b1;
        end else if (half < -CB'(32768)) begin
          v_d    = -SB'(32768);
          clip_d = 1'b1;
        end else begin
          v_d = half[SB-1:0];
        end
        state_d = StGain;
      end
      StGain: begin
        g_d     = gp[GPB-1:15];
        state_d = StFin;
      end
      StFin: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d             = 1'b1;
          out_data_d.step_clamped = clamped_q;
          out_data_d.clipped      = clip_q;
          out_data_d.sample       = g_q[SB-1:0];
          if (g_q > GB'(32767)) begin
            out_data_d.sample  = SB'(32767);
            out_data_d.clipped = 1'b1;
          end else if (g_q < -GB'(32768)) begin
            out_data_d.sample  = -SB'(32768);
            out_data_d.clipped = 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      rd_cnt_q    <= '0;
      h_cnt_q     <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      rd_cnt_q    <= rd_cnt_d;
      h_cnt_q     <= h_cnt_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    clamped_q  <= clamped_d;
    rem_q      <= rem_d;
    t_q        <= t_d;
    b_q        <= b_d;
    c_q        <= c_d;
    e_q        <= e_d;
    v_q        <= v_d;
    clip_q     <= clip_d;
    g_q        <= g_d;
    out_data_q <= out_data_d;
    // read data arrives in the cycle after its address, oldest ends in slot 0
    if (state_q == StRead && rd_cnt_q != 3'd0) begin
      y_q[0] <= y_q[1];
      y_q[1] <= y_q[2];
      y_q[2] <= y_q[3];
      y_q[3] <= $signed(rd_data);
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

>>> rtl/core/wto_checker.sv
// port-level checks on the wavetable oscillator, bound to the top level
module wto_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     in_op_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [wto_pkg::SampleBits-1:0] out_sample_i
);

  logic tick_fire, write_fire;
  assign tick_fire  = in_valid_i && in_ready_i && (in_op_i == wto_pkg::OpTick);
  assign write_fire = in_valid_i && in_ready_i && (in_op_i == wto_pkg::OpWrite);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i))
    else $error("result item dropped or changed while stalled");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire |=> !in_ready_i)
    else $error("input taken while a tick item is in progress");

  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_fire |=> in_ready_i)
    else $error("table write item blocked the input");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire |=> !$rose(out_valid_i))
    else $error("result item appeared right after a tick was accepted");

endmodule

bind wavetable_oscillator_cubic wto_checker u_wto_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.data.operation),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.data.sample)
);

>>> tb/wavetable_oscillator_cubic_test.sv
// self-checking testbench for the cubic wavetable oscillator
module wavetable_oscillator_cubic_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Phases        = 12;
  localparam int ItemsPerPhase = 150;
  localparam int SettleCycles  = 40;
  localparam int QuietLimit    = 2000;

  localparam int unsigned Aw    = wto_pkg::TableAw;
  localparam int unsigned LenW  = wto_pkg::LenBits;
  localparam int unsigned StepW = wto_pkg::PhaseBits;
  localparam int unsigned CfgW  = wto_pkg::CfgDataBits;

  typedef enum logic [1:0] {RowWrite, RowTick, RowReg} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] addr;
    longint      val;
    bit          typed;
    int          want_sample;
    bit          want_clip;
    bit          want_clamp;
  } plan_row_t;

  typedef struct {
    wto_pkg::out_item_t want;
    bit                 typed;
    wto_pkg::out_item_t typed_want;
  } tick_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [wto_pkg::CfgIdxBits-1:0]  cfg_index;
  logic [wto_pkg::CfgDataBits-1:0] cfg_data;

  wto_in_if  in_if ();
  wto_out_if out_if ();

  wavetable_oscillator_cubic dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the oscillator state
  logic signed [15:0]            wave_mem [wto_pkg::TableSize];
  bit                            loaded [wto_pkg::TableSize];
  longint unsigned               phase_acc = 0;
  logic [wto_pkg::LenBits-1:0]   len_reg = wto_pkg::TableLengthReset;
  logic [wto_pkg::PhaseBits-1:0] step_reg = wto_pkg::PhaseStepReset;
  logic [wto_pkg::AmpBits-1:0]   amp_reg = wto_pkg::AmplitudeReset;

  tick_result_t       pending_samples [$];
  tick_result_t       head;
  bit                 cue_typed = 1'b0;
  wto_pkg::out_item_t cue_want = '0;
  bit                 steady = 1'b0;
  int                 errors = 0;
  int                 n_ticks = 0;
  int                 n_writes = 0;
  int                 n_clipped = 0;
  int                 n_clamped = 0;
  int                 quiet = 0;

  plan_row_t plan [$] = '{
    '{RowWrite, 0, 16384, 0, 0, 0, 0},
    '{RowWrite, 1, 16384, 0, 0, 0, 0},
    '{RowWrite, 2, 16384, 0, 0, 0, 0},
    '{RowWrite, 2047, 16384, 0, 0, 0, 0},
    '{RowTick, 0, 0, 1, 16384, 0, 0},
    '{RowReg, wto_pkg::CfgTableLength, 4, 0, 0, 0, 0},
    '{RowWrite, 3, 16384, 0, 0, 0, 0},
    '{RowReg, wto_pkg::CfgPhaseStep, 32'h0010_0000, 0, 0, 0, 0},
    '{RowTick, 0, 0, 1, 16384, 0, 0},
    '{RowWrite, 0, 32767, 0, 0, 0, 0},
    '{RowWrite, 1, 32767, 0, 0, 0, 0},
    '{RowWrite, 2, 32767, 0, 0, 0, 0},
    '{RowWrite, 3, 32767, 0, 0, 0, 0},
    '{RowReg, wto_pkg::CfgAmplitude, 65535, 0, 0, 0, 0},
    '{RowTick, 0, 0, 1, 32767, 1, 0},
    '{RowWrite, 0, -32768, 0, 0, 0, 0},
    '{RowWrite, 1, -32768, 0, 0, 0, 0},
    '{RowWrite, 2, -32768, 0, 0, 0, 0},
    '{RowWrite, 3, -32768, 0, 0, 0, 0},
    '{RowTick, 0, 0, 1, -32768, 1, 0},
    '{RowReg, wto_pkg::CfgAmplitude, 0, 0, 0, 0, 0},
    '{RowTick, 0, 0, 1, 0, 0, 0},
    '{RowReg, wto_pkg::CfgAmplitude, 32768, 0, 0, 0, 0},
    '{RowWrite, 2, 32767, 0, 0, 0, 0},
    '{RowWrite, 3, 32767, 0, 0, 0, 0},
    // taps swing rail to rail, the cubic overshoots
    '{RowTick, 0, 0, 0, 0, 0, 0},
    '{RowReg, wto_pkg::CfgTableLength, 1, 0, 0, 0, 0},
    '{RowReg, wto_pkg::CfgPhaseStep, 32'hFFFF_FFFF, 0, 0, 0, 0},
    '{RowTick, 0, 0, 1, -32768, 0, 1},
    '{RowReg, wto_pkg::CfgTableLength, 0, 0, 0, 0, 0},
    '{RowTick, 0, 0, 1, -32768, 0, 1},
    '{RowReg, wto_pkg::CfgTableLength, 4095, 0, 0, 0, 0},
    '{RowTick, 0, 0, 0, 0, 0, 0},
    '{RowReg, wto_pkg::CfgPhaseStep, 32'h7FF0_0000, 0, 0, 0, 0},
    '{RowTick, 0, 0, 0, 0, 0, 0},
    '{RowTick, 0, 0, 0, 0, 0, 0},
    // phase now far beyond the shortened table
    '{RowReg, wto_pkg::CfgTableLength, 4, 0, 0, 0, 0},
    '{RowTick, 0, 0, 0, 0, 0, 0}
  };

  function automatic longint unsigned wrap_len();
    if (len_reg == 0) return 1;
    if (len_reg > wto_pkg::TableSize) return wto_pkg::TableSize;
    return len_reg;
  endfunction

  function automatic longint unsigned advanced_phase(output bit clamp);
    longint unsigned lim, stp;
    lim = wrap_len() << wto_pkg::PhaseFracBits;
    stp = step_reg;
    clamp = (stp >= lim);
    if (clamp) stp = lim - 1;
    return (phase_acc + stp) % lim;
  endfunction

  // k = 0..3 selects the taps one before to two after the integer phase
  function automatic int unsigned tap_index(longint unsigned ph, int k);
    longint unsigned n;
    n = wrap_len();
    return int'(((ph >> wto_pkg::PhaseFracBits) + n - 1 + k) % n);
  endfunction

  function automatic longint rnd16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint saturate16(longint v, inout bit hit);
    if (v > 32767) begin
      hit = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      hit = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  // advances the phase and returns the sample the block must emit
  function automatic wto_pkg::out_item_t predict_sample();
    wto_pkg::out_item_t res;
    bit                 clamp, hit;
    longint             y [4];
    longint             a, b, c, t, u, v, gain;
    hit = 1'b0;
    phase_acc = advanced_phase(clamp);
    u = (phase_acc % (64'd1 << wto_pkg::PhaseFracBits)) >> (wto_pkg::PhaseFracBits - 16);
    for (int k = 0; k < 4; k++) y[k] = wave_mem[tap_index(phase_acc, k)];
    // coefficients kept doubled so they stay integral
    a = (y[3] - y[0]) + 3 * (y[1] - y[2]);
    b = 2 * y[0] - 5 * y[1] + 4 * y[2] - y[3];
    c = y[2] - y[0];
    t = rnd16(a * u) + b;
    t = rnd16(t * u) + c;
    t = rnd16(t * u) + 2 * y[1];
    v = saturate16((t + 1) >>> 1, hit);
    gain = amp_reg;
    v = saturate16((v * gain + 16384) >>> 15, hit);
    res.sample = v[15:0];
    res.clipped = hit;
    res.step_clamped = clamp;
    return res;
  endfunction

  function automatic wto_pkg::in_item_t make_item(logic op, logic [Aw-1:0] idx,
                                                  logic [15:0] val);
    wto_pkg::in_item_t it;
    it.operation = op;
    it.entry_index = idx;
    it.entry_value = val;
    return it;
  endfunction

  function automatic logic [15:0] sample_value();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic compare_sample(wto_pkg::out_item_t want, wto_pkg::out_item_t got,
                                string tag);
    if (want.sample !== got.sample) begin
      $display("%0t: %s sample mismatch, expected %0d, actual %0d",
               $time, tag, want.sample, got.sample);
      errors++;
    end
    if (want.clipped !== got.clipped) begin
      $display("%0t: %s clipped mismatch, expected %0d, actual %0d",
               $time, tag, want.clipped, got.clipped);
      errors++;
    end
    if (want.step_clamped !== got.step_clamped) begin
      $display("%0t: %s step_clamped mismatch, expected %0d, actual %0d",
               $time, tag, want.step_clamped, got.step_clamped);
      errors++;
    end
  endtask

  task automatic send_item(wto_pkg::in_item_t it, bit typed = 1'b0,
                           wto_pkg::out_item_t want = '0);
    while (!steady && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    cue_typed = typed;
    cue_want = want;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    @(negedge clk_i);
  endtask

  // writes any tap the next tick would read that holds no sample yet
  task automatic fill_taps();
    bit              clamp;
    longint unsigned ph;
    int unsigned     i;
    ph = advanced_phase(clamp);
    for (int k = 0; k < 4; k++) begin
      i = tap_index(ph, k);
      if (!loaded[i]) send_item(make_item(wto_pkg::OpWrite, Aw'(i), sample_value()));
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [wto_pkg::CfgIdxBits-1:0] idx,
                           logic [wto_pkg::CfgDataBits-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      wto_pkg::CfgTableLength: len_reg = val[wto_pkg::LenBits-1:0];
      wto_pkg::CfgPhaseStep:   step_reg = val[wto_pkg::PhaseBits-1:0];
      wto_pkg::CfgAmplitude:   amp_reg = val[wto_pkg::AmpBits-1:0];
      default: ;
    endcase
  endtask

  // result channel first, so a fresh tick cannot satisfy an older result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_samples.size() == 0) begin
          $display("%0t: sample %0d arrived with none expected", $time, out_if.data.sample);
          errors++;
        end else begin
          head = pending_samples.pop_front();
          compare_sample(head.want, out_if.data, "predicted");
          if (head.typed) compare_sample(head.typed_want, out_if.data, "directed");
        end
        if (out_if.data.clipped) n_clipped++;
        if (out_if.data.step_clamped) n_clamped++;
      end
      if (in_if.valid && in_if.ready) begin
        if (in_if.data.operation == wto_pkg::OpWrite) begin
          wave_mem[in_if.data.entry_index] = in_if.data.entry_value;
          loaded[in_if.data.entry_index] = 1'b1;
          n_writes++;
        end else begin
          head.want = predict_sample();
          head.typed = cue_typed;
          head.typed_want = cue_want;
          pending_samples.push_back(head);
          n_ticks++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= steady || ($urandom_range(99) >= 6);
    end
  end

  initial begin
    wto_pkg::in_item_t             item;
    wto_pkg::out_item_t            want;
    longint unsigned               eff, lim;
    logic [wto_pkg::LenBits-1:0]   len_pick;
    logic [wto_pkg::PhaseBits-1:0] step_pick;
    logic [wto_pkg::AmpBits-1:0]   amp_pick;
    logic [Aw-1:0]                 idx;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[r]) begin
      case (plan[r].kind)
        RowReg: write_reg(plan[r].addr[wto_pkg::CfgIdxBits-1:0], plan[r].val[31:0]);
        RowWrite: send_item(make_item(wto_pkg::OpWrite, plan[r].addr[Aw-1:0],
                                      plan[r].val[15:0]));
        default: begin
          fill_taps();
          item = make_item(wto_pkg::OpTick, Aw'($urandom_range(2047)), 16'($urandom));
          want.sample = plan[r].want_sample[15:0];
          want.clipped = plan[r].want_clip;
          want.step_clamped = plan[r].want_clamp;
          send_item(item, plan[r].typed, want);
        end
      endcase
    end

    for (int p = 0; p < Phases; p++) begin
      steady = (p == 6 || p == 7);
      case (p)
        0: len_pick = 12'd2048;
        1: len_pick = 12'd1;
        2: len_pick = 12'd0;
        3: len_pick = 12'd4095;
        default:
          case ($urandom_range(5))
            0: len_pick = 12'd2048;
            1: len_pick = LenW'($urandom_range(2049, 4095));
            2: len_pick = LenW'($urandom_range(17, 2047));
            default: len_pick = LenW'($urandom_range(1, 16));
          endcase
      endcase
      write_reg(wto_pkg::CfgTableLength, CfgW'(len_pick));
      eff = wrap_len();
      lim = eff << wto_pkg::PhaseFracBits;
      case ($urandom_range(5))
        0: step_pick = $urandom;
        1: step_pick = '0;
        2: step_pick = (lim > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lim[31:0];
        3: step_pick = StepW'(lim - 1);
        default: step_pick = $urandom_range(0, int'(lim / 8));
      endcase
      write_reg(wto_pkg::CfgPhaseStep, step_pick);
      case (p)
        0: amp_pick = 16'hFFFF;
        1: amp_pick = 16'h0000;
        2: amp_pick = 16'h8000;
        default: amp_pick = ($urandom_range(3) == 0) ? 16'h8000 : 16'($urandom);
      endcase
      write_reg(wto_pkg::CfgAmplitude, CfgW'(amp_pick));
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if ($urandom_range(99) < 60) begin
          fill_taps();
          send_item(make_item(wto_pkg::OpTick, Aw'($urandom_range(2047)), 16'($urandom)));
        end else begin
          idx = ($urandom_range(9) < 7) ? Aw'($urandom_range(0, int'(eff) - 1))
                                        : Aw'($urandom_range(2047));
          send_item(make_item(wto_pkg::OpWrite, idx, sample_value()));
        end
      end
    end

    wait_idle();
    $display("ran %0d ticks and %0d table writes over %0d register settings",
             n_ticks, n_writes, Phases);
    $display("%0d samples saturated, %0d had the step clamped, %0d mismatches",
             n_clipped, n_clamped, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
